@@ rtl/core/bgd_pkg.sv @@
// Shared types, constants and codes for the button gesture detector.
package bgd_pkg;

    localparam int TIME_W   = 32;
    localparam int PADDR_W  = 4;
    localparam int EVQ_DEPTH = 4;
    localparam int EVQ_AW   = 2;
    localparam int EVQ_CW   = EVQ_AW + 1;

    localparam logic [1:0] ACT_LEVEL  = 2'd0;
    localparam logic [1:0] ACT_TICK   = 2'd1;
    localparam logic [1:0] ACT_RESYNC = 2'd2;

    localparam logic [2:0] EV_DOWN   = 3'd0;
    localparam logic [2:0] EV_UP     = 3'd1;
    localparam logic [2:0] EV_CLICK  = 3'd2;
    localparam logic [2:0] EV_DOUBLE = 3'd3;
    localparam logic [2:0] EV_LONG   = 3'd4;
    localparam logic [2:0] EV_HOLD   = 3'd5;

    localparam logic [1:0] REG_LONG_PRESS  = 2'd0;
    localparam logic [1:0] REG_DOUBLE_GAP  = 2'd1;
    localparam logic [1:0] REG_HOLD_REPEAT = 2'd2;
    localparam logic [1:0] REG_EVENT_MASK  = 2'd3;

    localparam logic [15:0] LONG_PRESS_RST  = 16'd1000;
    localparam logic [15:0] DOUBLE_GAP_RST  = 16'd300;
    localparam logic [15:0] HOLD_REPEAT_RST = 16'd200;
    localparam logic [5:0]  EVENT_MASK_RST  = 6'd60;

    typedef enum logic [1:0] {
        ST_IDLE    = 2'd0,
        ST_PRESSED = 2'd1,
        ST_WAITDBL = 2'd2,
        ST_HELD    = 2'd3
    } state_t;

    typedef struct packed {
        logic [1:0] action;
        logic       level;
    } cmd_item_t;

    typedef struct packed {
        logic [2:0]  event_type;
        logic [31:0] held_ms;
        logic        last;
    } evt_item_t;

    typedef struct packed {
        logic [15:0] long_press_ms;
        logic [15:0] double_gap_ms;
        logic [15:0] hold_repeat_ms;
        logic [5:0]  event_mask;
    } cfg_t;

    typedef struct packed {
        logic [1:0] cnt;
        evt_item_t  slot0;
        evt_item_t  slot1;
    } ev_pair_t;

    typedef struct packed {
        logic              valid;
        logic              room;
        logic [EVQ_CW-1:0] level;
    } evq_stat_t;

endpackage

@@ rtl/core/bgd_engine.sv @@
// Gesture state machine, deadline settlement and event selection for one item.
module bgd_engine
    import bgd_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      go,
    input  cmd_item_t item,
    input  cfg_t      cfg,
    output ev_pair_t  pair
);

    state_t            state_reg, state_next, st_mid;
    logic              level_reg, level_next;
    logic [1:0]        cc_reg, cc_next, cc_mid, cc_inc;
    logic [TIME_W-1:0] now_reg, now_eff;
    logic [TIME_W-1:0] press_reg, press_mid;
    logic [TIME_W-1:0] release_reg, release_mid;
    logic [TIME_W-1:0] hold_reg, hold_next;
    logic [TIME_W-1:0] el_press, el_hold, el_rel;

    logic       act_lvl, act_tick, act_sync, settle_en, chg;
    logic       lc0_v, lc1_v, st_v;
    logic [2:0] lc0_t, lc1_t, st_t;
    logic       e0_v, e1_v, e2_v;
    evt_item_t  e0, e1, e2;

    function automatic evt_item_t mk_event(input logic [2:0] t, input logic [TIME_W-1:0] el);
        evt_item_t ev;
        ev.event_type = t;
        ev.held_ms    = (t == EV_UP || t == EV_LONG || t == EV_HOLD) ? 32'(el) : 32'd0;
        ev.last       = 1'b0;
        return ev;
    endfunction

    assign act_lvl   = go && (item.action == ACT_LEVEL);
    assign act_tick  = go && (item.action == ACT_TICK);
    assign act_sync  = go && (item.action == ACT_RESYNC);
    assign settle_en = act_lvl || act_tick;
    assign chg       = act_lvl && (item.level != level_reg);
    assign now_eff   = act_tick ? now_reg + 1'b1 : now_reg;
    assign cc_inc    = (cc_reg == 2'd3) ? cc_reg : cc_reg + 2'd1;

    // level change step
    always_comb
    begin
        st_mid      = state_reg;
        cc_mid      = cc_reg;
        press_mid   = press_reg;
        release_mid = release_reg;
        lc0_v       = 1'b0;
        lc0_t       = EV_DOWN;
        lc1_v       = 1'b0;
        lc1_t       = EV_DOWN;
        if (chg)
        begin
            case (state_reg)
                ST_IDLE, ST_WAITDBL:
                begin
                    if (item.level)
                    begin
                        st_mid    = ST_PRESSED;
                        press_mid = now_eff;
                        lc0_v     = 1'b1;
                        lc0_t     = EV_DOWN;
                    end
                end
                ST_PRESSED:
                begin
                    if (!item.level)
                    begin
                        cc_mid = cc_inc;
                        lc0_v  = 1'b1;
                        lc0_t  = EV_UP;
                        lc1_v  = 1'b1;
                        if (cc_inc >= 2'd2)
                        begin
                            lc1_t  = EV_DOUBLE;
                            cc_mid = 2'd0;
                            st_mid = ST_IDLE;
                        end
                        else
                        begin
                            lc1_t = EV_CLICK;
                            if (cfg.event_mask[EV_DOUBLE])
                            begin
                                st_mid      = ST_WAITDBL;
                                release_mid = now_eff;
                            end
                            else
                            begin
                                cc_mid = 2'd0;
                                st_mid = ST_IDLE;
                            end
                        end
                    end
                end
                default:
                begin
                    if (!item.level)
                    begin
                        st_mid = ST_IDLE;
                        cc_mid = 2'd0;
                        lc0_v  = 1'b1;
                        lc0_t  = EV_UP;
                    end
                end
            endcase
        end
    end

    assign el_press = now_eff - press_mid;
    assign el_hold  = now_eff - hold_reg;
    assign el_rel   = now_eff - release_mid;

    // deadline settlement and next state
    always_comb
    begin
        state_next = st_mid;
        cc_next    = cc_mid;
        hold_next  = hold_reg;
        st_v       = 1'b0;
        st_t       = EV_LONG;
        if (settle_en)
        begin
            case (st_mid)
                ST_PRESSED:
                begin
                    if (el_press >= TIME_W'(cfg.long_press_ms))
                    begin
                        st_v       = 1'b1;
                        st_t       = EV_LONG;
                        state_next = ST_HELD;
                        hold_next  = now_eff;
                        cc_next    = 2'd0;
                    end
                end
                ST_HELD:
                begin
                    if (el_hold >= TIME_W'(cfg.hold_repeat_ms))
                    begin
                        st_v      = 1'b1;
                        st_t      = EV_HOLD;
                        hold_next = now_eff;
                    end
                end
                ST_WAITDBL:
                begin
                    if (el_rel >= TIME_W'(cfg.double_gap_ms))
                    begin
                        cc_next    = 2'd0;
                        state_next = ST_IDLE;
                    end
                end
                default:
                begin
                end
            endcase
        end
        if (act_sync)
        begin
            state_next = ST_IDLE;
            cc_next    = 2'd0;
        end
    end

    assign level_next = (act_sync || act_lvl) ? item.level : level_reg;

    // masked candidates, packed into at most two slots
    assign e0_v = lc0_v && cfg.event_mask[lc0_t];
    assign e1_v = lc1_v && cfg.event_mask[lc1_t];
    assign e2_v = st_v && cfg.event_mask[st_t];
    assign e0   = mk_event(lc0_t, el_press);
    assign e1   = mk_event(lc1_t, el_press);
    assign e2   = mk_event(st_t, el_press);

    always_comb
    begin
        evt_item_t s0, s1;
        logic      s0_v, s1_v;
        s0   = e2;
        s1   = e2;
        s0_v = 1'b0;
        s1_v = 1'b0;
        if (e0_v)
        begin
            s0   = e0;
            s0_v = 1'b1;
            s1   = e1_v ? e1 : e2;
            s1_v = e1_v || e2_v;
        end
        else if (e1_v)
        begin
            s0   = e1;
            s0_v = 1'b1;
            s1   = e2;
            s1_v = e2_v;
        end
        else
        begin
            s0   = e2;
            s0_v = e2_v;
        end
        s0.last    = !s1_v;
        s1.last    = 1'b1;
        pair.cnt   = {1'b0, s0_v} + {1'b0, s1_v};
        pair.slot0 = s0;
        pair.slot1 = s1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            level_reg   <= 1'b0;
            cc_reg      <= 2'd0;
            now_reg     <= '0;
            press_reg   <= '0;
            release_reg <= '0;
            hold_reg    <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            level_reg   <= level_next;
            cc_reg      <= cc_next;
            now_reg     <= now_eff;
            press_reg   <= press_mid;
            release_reg <= release_mid;
            hold_reg    <= hold_next;
        end
    end

endmodule

@@ rtl/core/bgd_evq.sv @@
// Small event queue: takes up to two events a cycle, hands out one.
module bgd_evq
    import bgd_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  ev_pair_t  push,
    input  logic      pop,
    output evt_item_t head,
    output evq_stat_t stat
);

    evt_item_t         mem_reg [EVQ_DEPTH];
    logic [EVQ_AW-1:0] wr_reg, rd_reg, wr_inc;
    logic [EVQ_CW-1:0] cnt_reg;

    assign wr_inc = wr_reg + 1'b1;
    assign head   = mem_reg[rd_reg];

    assign stat.valid = (cnt_reg != '0);
    assign stat.room  = (cnt_reg <= EVQ_CW'(EVQ_DEPTH - 2));
    assign stat.level = cnt_reg;

    always_ff @(posedge clk)
    begin
        if (push.cnt != 2'd0)
        begin
            mem_reg[wr_reg] <= push.slot0;
        end
        if (push.cnt == 2'd2)
        begin
            mem_reg[wr_inc] <= push.slot1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_reg + EVQ_AW'(push.cnt);
            rd_reg  <= rd_reg + EVQ_AW'(pop);
            cnt_reg <= cnt_reg + EVQ_CW'(push.cnt) - EVQ_CW'(pop);
        end
    end

endmodule

@@ rtl/core/button_gesture_detector_core.sv @@
// Top level of the button gesture detector: config registers, item register, event queue.
//
//   channel  direction  handshake                   payload
//   cmd      in         cmd_valid / cmd_stall       cmd  (action, level)
//   evt      out        evt_valid / evt_stall       evt  (event_type, held_ms, last)
//   apb      in         psel/penable/pwrite/pready  paddr, pwdata, prdata
//
// An item is registered on acceptance and processed once the queue has room; its
// events (up to two) enter a four-entry queue and leave one per cycle while evt_stall is low.
// Sustained rate: one item per cycle while the queue has room, bounded by one event
// per cycle on the evt port.
// Reset clears the control state and queue pointers and loads the default register values.
// A stalled evt port fills the queue; cmd_stall rises when an item is held and fewer than two entries are free.
module button_gesture_detector_core
    import bgd_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cmd_valid,
    output logic               cmd_stall,
    input  cmd_item_t          cmd,
    output logic               evt_valid,
    input  logic               evt_stall,
    output evt_item_t          evt,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    cfg_t      cfg_reg, cfg_next;
    logic      cmd_v_reg, cmd_v_next;
    cmd_item_t cmd_reg;
    logic      accept, go, pop, cfg_wr;
    ev_pair_t  pair;
    evq_stat_t qstat;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr)
        begin
            case (paddr[3:2])
                REG_LONG_PRESS:  cfg_next.long_press_ms  = pwdata[15:0];
                REG_DOUBLE_GAP:  cfg_next.double_gap_ms  = pwdata[15:0];
                REG_HOLD_REPEAT: cfg_next.hold_repeat_ms = pwdata[15:0];
                REG_EVENT_MASK:  cfg_next.event_mask     = pwdata[5:0];
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            REG_LONG_PRESS:  prdata = 32'(cfg_reg.long_press_ms);
            REG_DOUBLE_GAP:  prdata = 32'(cfg_reg.double_gap_ms);
            REG_HOLD_REPEAT: prdata = 32'(cfg_reg.hold_repeat_ms);
            REG_EVENT_MASK:  prdata = 32'(cfg_reg.event_mask);
            default:         prdata = 32'd0;
        endcase
    end

    assign go        = cmd_v_reg && qstat.room;
    assign cmd_stall = cmd_v_reg && !go;
    assign accept    = cmd_valid && !cmd_stall;
    assign cmd_v_next = accept || (cmd_v_reg && !go);

    assign evt_valid = qstat.valid;
    assign pop       = evt_valid && !evt_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.long_press_ms  <= LONG_PRESS_RST;
            cfg_reg.double_gap_ms  <= DOUBLE_GAP_RST;
            cfg_reg.hold_repeat_ms <= HOLD_REPEAT_RST;
            cfg_reg.event_mask     <= EVENT_MASK_RST;
            cmd_v_reg              <= 1'b0;
        end
        else
        begin
            cfg_reg   <= cfg_next;
            cmd_v_reg <= cmd_v_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg <= cmd;
        end
    end

    bgd_engine u_engine (
        .clk   (clk),
        .rst_n (rst_n),
        .go    (go),
        .item  (cmd_reg),
        .cfg   (cfg_reg),
        .pair  (pair)
    );

    bgd_evq u_evq (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (pair),
        .pop   (pop),
        .head  (evt),
        .stat  (qstat)
    );

    a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        qstat.level <= EVQ_CW'(EVQ_DEPTH))
        else $error("event queue overflow");

    a_no_push_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !go |-> pair.cnt == 2'd0)
        else $error("events produced without an item");

    a_resync_silent: assert property (@(posedge clk) disable iff (!rst_n)
        go && cmd_reg.action == ACT_RESYNC |-> pair.cnt == 2'd0)
        else $error("resync produced events");

    a_pair_last: assert property (@(posedge clk) disable iff (!rst_n)
        pair.cnt == 2'd2 |-> pair.slot1.last && !pair.slot0.last)
        else $error("last flag misplaced in event pair");

    a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> qstat.level == $past(qstat.level) + EVQ_CW'($past(pair.cnt)) - 1'b1)
        else $error("queue level inconsistent after pop");

endmodule
